// File: hw/rtl/hhlp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hhlp_pkg;

  typedef enum logic [2:0] {
    KIND_NAME  = 3'd0,
    KIND_VALUE = 3'd1,
    KIND_NEND  = 3'd2,
    KIND_HEND  = 3'd3,
    KIND_ERR   = 3'd4
  } kind_e;

  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChSp    = 8'h20;
  localparam logic [7:0] ChHt    = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;

  localparam int unsigned MaxResults = 3;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } result_t;

  // one request's worth of results, cnt is 1..3
  typedef struct packed {
    logic [1:0]  cnt;
    result_t [MaxResults-1:0] res;
  } cmd_t;

  function automatic logic tchar_ok(input logic [7:0] c);
    logic ok;
    ok = (c >= 8'd33) && (c <= 8'd126);
    unique case (c)
      8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C,
      8'h22, 8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D: ok = 1'b0;
      default: ;
    endcase
    return ok;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/http_header_line_parser.sv
// a request's first result passes the queue and then the output register
// throughput: one byte per cycle while the queue is not full; a byte's n
//   results share the single output register (up to three on a folded line)
// bytes that yield no result never reach the queue
// reset: asynchronous, clears parser state, queue and output valid
`timescale 1ns / 1ps
`default_nettype none

module http_header_line_parser #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       restart_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [2:0]      kind_o,
  output logic [7:0]      out_byte_o,
  output logic            last_o
);

  logic           accept;
  logic           push;
  logic           pop;
  logic           empty;
  logic           full;
  hhlp_pkg::cmd_t cmd_in;
  hhlp_pkg::cmd_t cmd_out;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  hhlp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_byte_i (in_byte_i),
    .restart_i (restart_i),
    .push_o    (push),
    .cmd_o     (cmd_in)
  );

  hhlp_fifo #(
    .Depth (QueueDepth),
    .Width ($bits(hhlp_pkg::cmd_t))
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (cmd_in),
    .pop_i   (pop),
    .rdata_o (cmd_out),
    .empty_o (empty),
    .full_o  (full)
  );

  hhlp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_out),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

// File: hw/rtl/hhlp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module hhlp_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic [7:0]    in_byte_i,
  input  wire logic          restart_i,
  output logic               push_o,
  output hhlp_pkg::cmd_t     cmd_o
);

  typedef enum logic [2:0] {
    PH_NAME  = 3'd0,
    PH_LWS   = 3'd1,
    PH_VALUE = 3'd2,
    PH_EOL   = 3'd3,
    PH_ERR   = 3'd4
  } phase_e;

  phase_e phase_q, phase_d;
  logic   first_lf_q, first_lf_d;
  logic   pair_q, pair_d;

  hhlp_pkg::result_t nm_res;
  phase_e            nm_phase;
  logic [7:0]        eol_first;
  logic [7:0]        eol_partner;
  logic              is_blank;
  logic              is_eol;

  always_comb begin
    if (hhlp_pkg::tchar_ok(in_byte_i)) begin
      nm_res   = '{kind: hhlp_pkg::KIND_NAME, data: in_byte_i};
      nm_phase = PH_NAME;
    end else if (in_byte_i == hhlp_pkg::ChColon) begin
      nm_res   = '{kind: hhlp_pkg::KIND_NEND, data: 8'd0};
      nm_phase = PH_LWS;
    end else begin
      nm_res   = '{kind: hhlp_pkg::KIND_ERR, data: 8'd0};
      nm_phase = PH_ERR;
    end
  end

  assign eol_first   = first_lf_q ? hhlp_pkg::ChLf : hhlp_pkg::ChCr;
  assign eol_partner = first_lf_q ? hhlp_pkg::ChCr : hhlp_pkg::ChLf;
  assign is_blank    = (in_byte_i == hhlp_pkg::ChSp) || (in_byte_i == hhlp_pkg::ChHt);
  assign is_eol      = (in_byte_i == hhlp_pkg::ChCr) || (in_byte_i == hhlp_pkg::ChLf);

  always_comb begin
    phase_d    = phase_q;
    first_lf_d = first_lf_q;
    pair_d     = pair_q;
    cmd_o      = '0;
    if (restart_i) begin
      phase_d    = PH_NAME;
      first_lf_d = 1'b0;
      pair_d     = 1'b0;
    end else begin
      unique case (phase_q)
        PH_NAME: begin
          cmd_o.cnt    = 2'd1;
          cmd_o.res[0] = nm_res;
          phase_d      = nm_phase;
        end
        PH_LWS, PH_VALUE: begin
          if (is_eol) begin
            phase_d    = PH_EOL;
            first_lf_d = (in_byte_i == hhlp_pkg::ChLf);
            pair_d     = 1'b0;
          end else if (!(is_blank && (phase_q == PH_LWS))) begin
            cmd_o.cnt    = 2'd1;
            cmd_o.res[0] = '{kind: hhlp_pkg::KIND_VALUE, data: in_byte_i};
            phase_d      = PH_VALUE;
          end
        end
        PH_EOL: begin
          if (!pair_q && (in_byte_i == eol_partner)) begin
            pair_d = 1'b1;
          end else if (is_blank) begin
            cmd_o.res[0] = '{kind: hhlp_pkg::KIND_VALUE, data: eol_first};
            if (pair_q) begin
              cmd_o.cnt    = 2'd3;
              cmd_o.res[1] = '{kind: hhlp_pkg::KIND_VALUE, data: eol_partner};
              cmd_o.res[2] = '{kind: hhlp_pkg::KIND_VALUE, data: in_byte_i};
            end else begin
              cmd_o.cnt    = 2'd2;
              cmd_o.res[1] = '{kind: hhlp_pkg::KIND_VALUE, data: in_byte_i};
            end
            phase_d    = PH_VALUE;
            first_lf_d = 1'b0;
            pair_d     = 1'b0;
          end else begin
            cmd_o.cnt    = 2'd2;
            cmd_o.res[0] = '{kind: hhlp_pkg::KIND_HEND, data: 8'd0};
            cmd_o.res[1] = nm_res;
            phase_d      = nm_phase;
            first_lf_d   = 1'b0;
            pair_d       = 1'b0;
          end
        end
        default: begin
          cmd_o.cnt    = 2'd1;
          cmd_o.res[0] = '{kind: hhlp_pkg::KIND_ERR, data: 8'd0};
          phase_d      = PH_ERR;
        end
      endcase
    end
  end

  assign push_o = accept_i && (cmd_o.cnt != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_NAME;
      first_lf_q <= 1'b0;
      pair_q     <= 1'b0;
    end else if (accept_i) begin
      phase_q    <= phase_d;
      first_lf_q <= first_lf_d;
      pair_q     <= pair_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/hhlp_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

// depth of at least two
module hhlp_fifo #(
  parameter int unsigned Depth = 2,
  parameter int unsigned Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             pop_i,
  output logic [Width-1:0]      rdata_o,
  output logic                  empty_o,
  output logic                  full_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d;
  logic [PtrW-1:0]  rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(Depth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/hhlp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module hhlp_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire hhlp_pkg::cmd_t cmd_i,
  input  wire logic           empty_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output logic [2:0]          kind_o,
  output logic [7:0]          out_byte_o,
  output logic                last_o
);

  logic              valid_q;
  logic [1:0]        idx_q, idx_d;
  hhlp_pkg::result_t res_q;
  hhlp_pkg::result_t cur;
  logic              last_q;
  logic              is_last;
  logic              load;

  assign load    = (!valid_q || !out_stall_i) && !empty_i;
  assign cur     = cmd_i.res[idx_q];
  assign is_last = (idx_q == (cmd_i.cnt - 2'd1));
  assign pop_o   = load && is_last;
  assign idx_d   = is_last ? 2'd0 : idx_q + 2'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else if (load) begin
      valid_q <= 1'b1;
      idx_q   <= idx_d;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q  <= cur;
      last_q <= is_last;
    end
  end

  assign out_valid_o = valid_q;
  assign kind_o      = res_q.kind;
  assign out_byte_o  = res_q.data;
  assign last_o      = last_q;

endmodule

`default_nettype wire
